>>> rtl/bpd_pkg.sv
// Shared types, constants and codes of the bucket priority deque.
`default_nettype none

package bpd_pkg;

    localparam int LEVEL_DEPTH = 32;
    localparam int LEVEL_COUNT = 32;
    localparam int COORD_BITS  = 8;

    localparam int LEVEL_BITS = $clog2(LEVEL_COUNT);
    localparam int SLOT_BITS  = $clog2(LEVEL_DEPTH);
    localparam int FILL_BITS  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_BITS  = LEVEL_BITS + SLOT_BITS;
    localparam int STORE_WORDS = LEVEL_COUNT * LEVEL_DEPTH;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [FILL_BITS-1:0]  fill_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } entry_t;

    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_PUSH     = 2'd1,
        ACT_POP_HEAD = 2'd2,
        ACT_POP_TAIL = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_PUSH     = 3'd1,
        OP_RANGE    = 3'd2,
        OP_POP_HEAD = 3'd3,
        OP_POP_TAIL = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        op_t    op;
        level_t level;
        entry_t entry;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/bucket_priority_deque.sv
// Top level of the bucket priority deque: front part, command queue and back part.
`default_nettype none

// A command (clear, push, pop newest or pop oldest) is transferred at a rising edge where
// start is high and busy is low. busy then stays high until the front register has handed
// the command to the command queue, so a new command can be transferred only after that.
// Its result appears on the result ports, marked by done, for exactly one cycle. The command
// passes the front register, then a slot of the command queue, and then the back part takes
// it from the head of the command queue, updates the level pointers, finds the lowest
// non-empty level with a priority encoder and accesses the entry store, whose read data is
// registered. The receiver cannot stall the result. Reset clears all level pointers and
// fill counts at once; the entry store needs no clearing pass, since a pop only reads slots
// that a push has written.
module bucket_priority_deque (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire logic [1:0]     action,
    input  wire logic [7:0]     priority_req,
    input  wire logic [7:0]     entry_x,
    input  wire logic [7:0]     entry_y,
    output logic                done,
    output logic [1:0]          status,
    output logic [7:0]          popped_x,
    output logic [7:0]          popped_y,
    output logic [4:0]          popped_level,
    output logic [5:0]          level_count
);

    bpd_pkg::cmd_t front_cmd;
    bpd_pkg::cmd_t head_cmd;
    logic          cmd_push;
    logic          fifo_full;
    logic          head_valid;
    logic          cmd_pop;

    bpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .priority_req (priority_req),
        .entry_x      (entry_x),
        .entry_y      (entry_y),
        .fifo_full    (fifo_full),
        .busy         (busy),
        .cmd_push     (cmd_push),
        .cmd          (front_cmd)
    );

    bpd_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (front_cmd),
        .pop        (cmd_pop),
        .full       (fifo_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .done         (done),
        .status       (status),
        .popped_x     (popped_x),
        .popped_y     (popped_y),
        .popped_level (popped_level),
        .level_count  (level_count)
    );

endmodule

`default_nettype wire

>>> rtl/bpd_front.sv
// Front part: takes a command, classifies it and hands it to the command queue.
`default_nettype none

module bpd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     action,
    input  wire logic [7:0]     priority_req,
    input  wire logic [7:0]     entry_x,
    input  wire logic [7:0]     entry_y,
    input  wire logic           fifo_full,
    output logic                busy,
    output logic                cmd_push,
    output bpd_pkg::cmd_t       cmd
);

    logic          front_valid_reg;
    logic          front_valid_next;
    bpd_pkg::cmd_t cmd_reg;
    bpd_pkg::cmd_t cmd_next;
    bpd_pkg::cmd_t cmd_class;
    logic          accept;

    assign accept   = start && !front_valid_reg;
    assign busy     = front_valid_reg;
    assign cmd_push = front_valid_reg && !fifo_full;
    assign cmd      = cmd_reg;

    always_comb
    begin
        cmd_class.level   = bpd_pkg::level_t'(priority_req);
        cmd_class.entry.x = bpd_pkg::coord_t'(entry_x);
        cmd_class.entry.y = bpd_pkg::coord_t'(entry_y);
        unique case (bpd_pkg::action_t'(action))
            bpd_pkg::ACT_CLEAR:
            begin
                cmd_class.op = bpd_pkg::OP_CLEAR;
            end
            bpd_pkg::ACT_PUSH:
            begin
                // Out-of-range priorities are settled here, before any level is touched.
                if (9'(priority_req) >= 9'(bpd_pkg::LEVEL_COUNT))
                begin
                    cmd_class.op = bpd_pkg::OP_RANGE;
                end
                else
                begin
                    cmd_class.op = bpd_pkg::OP_PUSH;
                end
            end
            bpd_pkg::ACT_POP_HEAD:
            begin
                cmd_class.op = bpd_pkg::OP_POP_HEAD;
            end
            default:
            begin
                cmd_class.op = bpd_pkg::OP_POP_TAIL;
            end
        endcase
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        cmd_next         = cmd_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
            cmd_next         = cmd_class;
        end
        else if (cmd_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> rtl/bpd_cmd_fifo.sv
// Short command queue between the front and back parts.
`default_nettype none

module bpd_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bpd_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output bpd_pkg::cmd_t       head_cmd
);

    bpd_pkg::cmd_t                       slots_reg [bpd_pkg::FIFO_DEPTH];
    logic [bpd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg;
    logic [bpd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_next;
    logic [bpd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg;
    logic [bpd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_next;
    logic [bpd_pkg::FIFO_CNT_BITS-1:0]   count_reg;
    logic [bpd_pkg::FIFO_CNT_BITS-1:0]   count_next;
    logic                                do_push;
    logic                                do_pop;

    assign full       = (count_reg == bpd_pkg::FIFO_CNT_BITS'(bpd_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == bpd_pkg::FIFO_PTR_BITS'(bpd_pkg::FIFO_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bpd_pkg::FIFO_PTR_BITS'(bpd_pkg::FIFO_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bpd_back.sv
// Back part: level pointers, entry store and result registers.
`default_nettype none

module bpd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire bpd_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    output logic                done,
    output logic [1:0]          status,
    output logic [7:0]          popped_x,
    output logic [7:0]          popped_y,
    output logic [4:0]          popped_level,
    output logic [5:0]          level_count
);

    bpd_pkg::slot_t  head_reg [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::slot_t  head_next [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::slot_t  tail_reg [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::slot_t  tail_next [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::fill_t  fill_reg [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::fill_t  fill_next [bpd_pkg::LEVEL_COUNT];
    bpd_pkg::level_t lowest_reg;
    bpd_pkg::level_t lowest_next;

    bpd_pkg::entry_t entry_store [bpd_pkg::STORE_WORDS];
    bpd_pkg::entry_t rd_data_reg;
    bpd_pkg::addr_t  mem_addr;
    logic            mem_we;

    logic                done_reg;
    logic                done_next;
    bpd_pkg::status_t    status_reg;
    bpd_pkg::status_t    status_next;
    bpd_pkg::level_t     level_out_reg;
    bpd_pkg::level_t     level_out_next;
    bpd_pkg::fill_t      count_reg;
    bpd_pkg::fill_t      count_next;
    logic                pop_out_reg;
    logic                pop_out_next;

    logic [bpd_pkg::LEVEL_COUNT-1:0] nonempty;
    logic [bpd_pkg::LEVEL_COUNT-1:0] search_mask;
    logic [bpd_pkg::LEVEL_COUNT-1:0] candidates;
    logic [bpd_pkg::LEVEL_COUNT-1:0] first_hot;
    logic                            found;
    bpd_pkg::level_t                 found_lvl;
    logic                            is_pop;
    bpd_pkg::level_t                 sel_lvl;
    bpd_pkg::slot_t                  head_sel;
    bpd_pkg::slot_t                  tail_sel;
    bpd_pkg::fill_t                  fill_sel;
    bpd_pkg::slot_t                  slot;

    // The back part drains one command per cycle, so the queue never backs up here.
    assign cmd_pop = cmd_valid;

    // Levels below lowest_reg are known to be empty, so only those at or above it count.
    always_comb
    begin
        for (int i = 0; i < bpd_pkg::LEVEL_COUNT; i++)
        begin
            nonempty[i]    = (fill_reg[i] != '0);
            search_mask[i] = (bpd_pkg::level_t'(i) >= lowest_reg);
        end
        candidates = nonempty & search_mask;
        first_hot  = candidates & (~candidates + 1'b1);
        found      = (candidates != '0);
        found_lvl  = '0;
        for (int i = 0; i < bpd_pkg::LEVEL_COUNT; i++)
        begin
            if (first_hot[i])
            begin
                found_lvl = found_lvl | bpd_pkg::level_t'(i);
            end
        end
    end

    assign is_pop   = (cmd.op == bpd_pkg::OP_POP_HEAD) || (cmd.op == bpd_pkg::OP_POP_TAIL);
    assign sel_lvl  = is_pop ? found_lvl : cmd.level;
    assign head_sel = head_reg[sel_lvl];
    assign tail_sel = tail_reg[sel_lvl];
    assign fill_sel = fill_reg[sel_lvl];

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        lowest_next    = lowest_reg;
        done_next      = cmd_valid;
        status_next    = bpd_pkg::ST_OK;
        level_out_next = '0;
        count_next     = '0;
        pop_out_next   = 1'b0;
        mem_we         = 1'b0;
        slot           = head_sel;

        if (cmd_valid)
        begin
            unique case (cmd.op)
                bpd_pkg::OP_CLEAR:
                begin
                    for (int i = 0; i < bpd_pkg::LEVEL_COUNT; i++)
                    begin
                        head_next[i] = '0;
                        tail_next[i] = '0;
                        fill_next[i] = '0;
                    end
                    lowest_next = '0;
                end
                bpd_pkg::OP_RANGE:
                begin
                    status_next = bpd_pkg::ST_RANGE;
                end
                bpd_pkg::OP_PUSH:
                begin
                    if (fill_sel == bpd_pkg::fill_t'(bpd_pkg::LEVEL_DEPTH))
                    begin
                        status_next = bpd_pkg::ST_FULL;
                        count_next  = fill_sel;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        head_next[sel_lvl] =
                            (head_sel == bpd_pkg::slot_t'(bpd_pkg::LEVEL_DEPTH - 1))
                            ? '0 : head_sel + 1'b1;
                        fill_next[sel_lvl] = fill_sel + 1'b1;
                        count_next         = fill_sel + 1'b1;
                        if (cmd.level < lowest_reg)
                        begin
                            lowest_next = cmd.level;
                        end
                    end
                end
                bpd_pkg::OP_POP_HEAD,
                bpd_pkg::OP_POP_TAIL:
                begin
                    if (!found)
                    begin
                        status_next = bpd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        lowest_next = found_lvl;
                        if (cmd.op == bpd_pkg::OP_POP_HEAD)
                        begin
                            // The newest entry sits just behind the head, wrapping at slot zero.
                            slot = (head_sel == '0)
                                   ? bpd_pkg::slot_t'(bpd_pkg::LEVEL_DEPTH - 1)
                                   : head_sel - 1'b1;
                            head_next[sel_lvl] = slot;
                        end
                        else
                        begin
                            slot = tail_sel;
                            tail_next[sel_lvl] =
                                (tail_sel == bpd_pkg::slot_t'(bpd_pkg::LEVEL_DEPTH - 1))
                                ? '0 : tail_sel + 1'b1;
                        end
                        fill_next[sel_lvl] = fill_sel - 1'b1;
                        count_next         = fill_sel - 1'b1;
                        level_out_next     = found_lvl;
                        pop_out_next       = 1'b1;
                    end
                end
                default:
                begin
                    status_next = bpd_pkg::ST_OK;
                end
            endcase
        end
    end

    assign mem_addr = {sel_lvl, slot};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bpd_pkg::LEVEL_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            lowest_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            lowest_reg <= lowest_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        level_out_reg <= level_out_next;
        count_reg     <= count_next;
        pop_out_reg   <= pop_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_store[mem_addr] <= cmd.entry;
        end
        rd_data_reg <= entry_store[mem_addr];
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_x     = pop_out_reg ? 8'(rd_data_reg.x) : '0;
    assign popped_y     = pop_out_reg ? 8'(rd_data_reg.y) : '0;
    assign popped_level = 5'(level_out_reg);
    assign level_count  = 6'(count_reg);

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |=> done_reg)
        else $error("command taken by the back part produced no result");

    a_below_lowest_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty & ~search_mask) == '0)
        else $error("a level below the lowest marker holds entries");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (fill_sel <= bpd_pkg::fill_t'(bpd_pkg::LEVEL_DEPTH)))
        else $error("level fill count above level depth");

    a_empty_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && is_pop && !found) |=> (!pop_out_reg && count_reg == '0))
        else $error("empty pop reported an entry");
`endif

endmodule

`default_nettype wire
